### rtl/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types, character codes and the digit-to-ASCII function for the
// fixed-point coordinate text formatter.
// ----------------------------------------------------------------------------
package fct_pkg;

    localparam int unsigned TWIP_W  = 24;
    localparam int unsigned FRAC_W  = 8;
    localparam int unsigned DIG_N   = 7;
    localparam int unsigned DIG_W   = 4 * DIG_N;
    localparam int unsigned DCNT_W  = $clog2(DIG_N + 1);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef struct packed {
        logic                neg;
        logic [FRAC_W-1:0]   frac;
        logic [TWIP_W-1:0]   twips;
        logic [TWIP_W-1:0]   mag;
    } t_job;

    typedef struct packed {
        logic                start;
        logic [TWIP_W-1:0]   mag;
    } t_dab_req;

    typedef struct packed {
        logic                done;
        logic [DIG_W-1:0]    bcd;
    } t_dab_rsp;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else begin
            c = CH_UPA + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

### rtl/fct_dabble.sv
// ----------------------------------------------------------------------------
// fct_dabble
// Bit-serial binary to BCD converter (shift and add-3), one input bit per
// cycle, seven decimal digits out.
// ----------------------------------------------------------------------------
module fct_dabble (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fct_pkg::t_dab_req    i_req,
    output fct_pkg::t_dab_rsp    o_rsp
);
    import fct_pkg::*;

    localparam int unsigned CNT_W = $clog2(TWIP_W);

    logic [TWIP_W-1:0] r_sh;
    logic [DIG_W-1:0]  r_bcd;
    logic [DIG_W-1:0]  n_bcd;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              w_last;

    assign w_last = r_busy && (r_cnt == CNT_W'(TWIP_W - 1));

    always_comb begin
        logic [DIG_W-1:0] adj;
        logic [3:0]       d;
        adj = '0;
        for (int i = 0; i < DIG_N; i++) begin
            d = r_bcd[4*i +: 4];
            adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
        n_bcd = {adj[DIG_W-2:0], r_sh[TWIP_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= w_last && !i_req.start;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_sh   <= i_req.mag;
                r_bcd  <= '0;
            end else if (r_busy) begin
                r_bcd <= n_bcd;
                r_sh  <= {r_sh[TWIP_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.bcd  = r_bcd;

endmodule

### rtl/fct_fmt.sv
// ----------------------------------------------------------------------------
// fct_fmt
// Text sequencer: walks a nibble shift register one digit per cycle when not
// stalled by the output, drops leading zeros and drives the registered character output.
// ----------------------------------------------------------------------------
module fct_fmt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fct_pkg::t_job        i_job,
    output fct_pkg::t_dab_req    o_dab_req,
    input  fct_pkg::t_dab_rsp    i_dab_rsp,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_char_out,
    output logic                 o_last_char
);
    import fct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_PREFIX,
        S_SKIP,
        S_DIGITS,
        S_DOT
    } t_state;

    t_state             r_state;
    logic               r_neg;
    logic               r_hex;
    logic               r_fph;
    logic [FRAC_W-1:0]  r_frac;
    logic [DIG_W-1:0]   r_dig;
    logic [DCNT_W-1:0]  r_cnt;
    logic               r_valid;
    logic [7:0]         r_char;
    logic               r_last;
    logic               w_free;
    logic               w_accept;
    logic               w_emit;
    logic [3:0]         w_top;

    assign w_free     = !r_valid || i_out_ready;
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_top      = r_dig[DIG_W-1 -: 4];
    assign o_in_ready = (r_state == S_IDLE);

    // states that load a character once the output register is free
    assign w_emit = (r_state == S_PREFIX) || (r_state == S_DIGITS) || (r_state == S_DOT);

    // decimal path only when the fraction is zero
    assign o_dab_req.start = w_accept && (i_job.frac == '0);
    assign o_dab_req.mag   = i_job.mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (w_free) begin
                r_valid <= w_emit;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_neg  <= i_job.neg;
                        r_frac <= i_job.frac;
                        r_fph  <= 1'b0;
                        r_cnt  <= DCNT_W'(DIG_N);
                        if (i_job.frac == '0) begin
                            r_hex   <= 1'b0;
                            r_state <= S_CONV;
                        end else begin
                            r_hex   <= 1'b1;
                            r_dig   <= {{(DIG_W-TWIP_W){1'b0}}, i_job.twips};
                            r_state <= S_PREFIX;
                        end
                    end
                end
                S_CONV: begin
                    if (i_dab_rsp.done) begin
                        r_dig   <= i_dab_rsp.bcd;
                        r_state <= r_neg ? S_PREFIX : S_SKIP;
                    end
                end
                S_PREFIX: begin
                    if (w_free) begin
                        r_char  <= r_hex ? CH_HASH : CH_MINUS;
                        r_last  <= 1'b0;
                        r_state <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    // at least one digit always remains
                    if (w_top == 4'd0 && r_cnt > DCNT_W'(1)) begin
                        r_dig <= {r_dig[DIG_W-5:0], 4'd0};
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_state <= S_DIGITS;
                    end
                end
                S_DIGITS: begin
                    if (w_free) begin
                        r_char  <= digit_char(w_top);
                        r_last  <= (r_cnt == DCNT_W'(1)) && (!r_hex || r_fph);
                        r_dig   <= {r_dig[DIG_W-5:0], 4'd0};
                        r_cnt   <= r_cnt - 1'b1;
                        if (r_cnt == DCNT_W'(1)) begin
                            r_state <= (r_hex && !r_fph) ? S_DOT : S_IDLE;
                        end
                    end
                end
                S_DOT: begin
                    if (w_free) begin
                        r_char  <= CH_DOT;
                        r_last  <= 1'b0;
                        r_fph   <= 1'b1;
                        r_dig   <= {r_frac, {(DIG_W-FRAC_W){1'b0}}};
                        r_cnt   <= DCNT_W'(2);
                        r_state <= S_DIGITS;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_valid;
    assign o_char_out  = r_char;
    assign o_last_char = r_last;

endmodule

### rtl/fixed_coord_to_text_top.sv
// ----------------------------------------------------------------------------
// fixed_coord_to_text_top
// Formats one signed Q24.8 twip coordinate as ASCII text, one character per beat.
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_ready carry i_coord_fixed in 1/256 twip;
//   it splits by floor into 24-bit whole twips and an 8-bit fraction.
// output channel: o_out_valid / i_out_ready carry o_char_out and
//   o_last_char, which marks the final character of one coordinate.
// zero fraction: decimal text, '-' for negatives, 1 to 8 beats. The
//   bit-serial BCD converter runs first, then leading zeros drop at one
//   digit per cycle, then one character per cycle while the output is
//   not stalled.
// nonzero fraction: '#', hex whole twips, '.', two hex fraction digits,
//   5 to 10 beats.
// One coordinate is in work at a time; the next is taken the cycle after
//   its last character is registered. Reset clears the sequencer and the
//   output valid.
// A stall on the output holds the current beat; the sequencer waits at its
//   next character.
// ----------------------------------------------------------------------------
module fixed_coord_to_text_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [31:0]  i_coord_fixed,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_char_out,
    output logic                o_last_char
);
    import fct_pkg::*;

    t_job     w_job;
    t_dab_req w_dab_req;
    t_dab_rsp w_dab_rsp;

    // floor split; magnitude of the whole twips for the decimal path
    assign w_job.neg   = i_coord_fixed[31];
    assign w_job.frac  = i_coord_fixed[FRAC_W-1:0];
    assign w_job.twips = i_coord_fixed[31:FRAC_W];
    assign w_job.mag   = i_coord_fixed[31] ? (TWIP_W'(0) - i_coord_fixed[31:FRAC_W])
                                           : i_coord_fixed[31:FRAC_W];

    fct_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dab_req),
        .o_rsp   (w_dab_rsp)
    );

    fct_fmt u_fmt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_job       (w_job),
        .o_dab_req   (w_dab_req),
        .i_dab_rsp   (w_dab_rsp),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_char_out  (o_char_out),
        .o_last_char (o_last_char)
    );

endmodule

### tb/tb_fixed_coord_to_text_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_coord_to_text_top
// Drives signed Q24.8 twip coordinates into the text formatter and checks
// every character beat against a predicted text stream: decimal text for
// whole coordinates, '#'-prefixed hex text with a two-digit fraction
// otherwise. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_fixed_coord_to_text_top;
    import fct_pkg::*;

    localparam int    CLK_HALF    = 5;
    localparam int    RESET_CYC   = 7;
    localparam int    DRAIN_CYC   = 40;
    localparam int    CYCLE_LIMIT = 700_000;
    localparam int    RANDOM_N    = 500;
    localparam int    MAX_SHOWN   = 10;
    localparam string HEX_GLYPHS  = "0123456789ABCDEF";

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_text_beat;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [31:0] i_coord_fixed;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [7:0]         o_char_out;
    logic               o_last_char;

    t_text_beat  text_queue[$];
    t_text_beat  want_beat;
    int          fail_count  = 0;
    int          cycle_count = 0;
    int          rx_wait     = 0;
    bit          tx_idle     = 1'b1;
    bit          rx_idle     = 1'b1;

    fixed_coord_to_text_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_coord_fixed (i_coord_fixed),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_char_out    (o_char_out),
        .o_last_char   (o_last_char)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // text the formatter should produce for one coordinate
    function automatic void predict_coord_text(input logic [31:0] coord);
        logic        neg;
        logic [7:0]  frac;
        logic [23:0] whole;
        logic [23:0] mag;
        logic [3:0]  nib;
        logic [7:0]  txt [0:9];
        logic [7:0]  dec [0:7];
        int unsigned m;
        int          len;
        int          nd;
        bit          lead;
        t_text_beat  b;
        neg   = coord[31];
        frac  = coord[7:0];
        whole = coord[31:8];
        len   = 0;
        if (frac == 8'd0) begin
            if (neg) begin
                txt[len] = CH_MINUS;
                len++;
                mag = 24'd0 - whole;
            end else begin
                mag = whole;
            end
            m  = mag;
            nd = 0;
            do begin
                dec[nd] = CH_ZERO + 8'(m % 10);
                m = m / 10;
                nd++;
            end while (m != 0);
            for (int i = nd - 1; i >= 0; i--) begin
                txt[len] = dec[i];
                len++;
            end
        end else begin
            txt[len] = CH_HASH;
            len++;
            // negatives keep all six digits of the 24-bit two's complement
            lead = neg;
            for (int i = 5; i >= 0; i--) begin
                nib = whole[4*i +: 4];
                if (lead || nib != 4'd0 || i == 0) begin
                    lead = 1'b1;
                    txt[len] = HEX_GLYPHS[nib];
                    len++;
                end
            end
            txt[len] = CH_DOT;
            len++;
            txt[len] = HEX_GLYPHS[frac[7:4]];
            len++;
            txt[len] = HEX_GLYPHS[frac[3:0]];
            len++;
        end
        for (int k = 0; k < len; k++) begin
            b.ch   = txt[k];
            b.last = (k == len - 1);
            text_queue.insert(text_queue.size(), b);
        end
    endfunction

    function automatic logic [31:0] draw_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0: ;
            1: r[7:0] = 8'd0;
            2: r = $urandom_range(0, 32'h0000_FFFF);
            3: r = 32'd0 - $urandom_range(1, 32'h0000_FFFF);
            4: r = 32'd0 - ($urandom_range(0, 99999) << 8);
            default: r[31:8] = $urandom_range(0, 1) ? 24'hFF_FFFF : 24'h00_0000;
        endcase
        return r;
    endfunction

    task automatic send_coord(input logic [31:0] coord);
        int gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_coord_fixed <= coord;
        do @(posedge i_clk); while (!o_in_ready);
        predict_coord_text(coord);
    endtask

    task automatic wait_text_drained();
        while (text_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_corners();
        logic [31:0] corners [$];
        corners = '{32'h0000_0000, 32'h0000_0001, 32'h0000_00FF, 32'h0000_0100,
                    32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FF00, 32'h8000_0001, 32'h0000_0080, 32'hFFFF_FF80,
                    32'h0000_0A00, 32'h0010_0000, 32'h0001_0080, 32'hFFF0_0000,
                    32'hFFF0_0010, 32'h1234_5678, 32'hABCD_EF01, 32'h0098_9600,
                    32'h0098_9680, 32'hFF67_6A00, 32'h5555_5555, 32'hAAAA_AAAA};
        foreach (corners[i]) send_coord(corners[i]);
    endtask

    // sender holds off until all pending text is out, then bursts again
    task automatic test_drain_between_bursts();
        for (int burst = 0; burst < 3; burst++) begin
            for (int i = 0; i < 4; i++) send_coord(draw_coord());
            i_in_valid <= 1'b0;
            wait_text_drained();
        end
    endtask

    task automatic test_random_coords();
        for (int i = 0; i < RANDOM_N; i++) begin
            if (i % 40 == 0) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            send_coord(draw_coord());
        end
    endtask

    // output side: random stall per beat, compare each beat in order
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (text_queue.size() == 0) begin
                    if (fail_count < MAX_SHOWN)
                        $display("unexpected beat: char %h last %b", o_char_out, o_last_char);
                    fail_count++;
                end else begin
                    want_beat = text_queue.pop_front();
                    if (o_char_out !== want_beat.ch || o_last_char !== want_beat.last) begin
                        if (fail_count < MAX_SHOWN)
                            $display("beat mismatch: char exp %h got %h, last exp %b got %b",
                                     want_beat.ch, o_char_out, want_beat.last, o_last_char);
                        fail_count++;
                    end
                end
                rx_wait = rx_idle ? $urandom_range(0, 19) : 0;
            end else if (rx_wait != 0) begin
                rx_wait = rx_wait - 1;
            end
            i_out_ready <= (rx_wait == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_coord_fixed = '0;
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_drain_between_bursts();
        test_random_coords();

        i_in_valid <= 1'b0;
        wait_text_drained();
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (fail_count == 0 && text_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/fct_pkg.sv
rtl/fct_dabble.sv
rtl/fct_fmt.sv
rtl/fixed_coord_to_text_top.sv
tb/tb_fixed_coord_to_text_top.sv
